### hdl/rsrf_pkg.sv
// rsrf_pkg: shared types and constants for the range spike rejection filter
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package rsrf_pkg;

  // field widths
  localparam int DIST_W  = 16;
  localparam int COUNT_W = 8;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_SENTINEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAFE_DISTANCE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLIND_ZONE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLIND_JUMP_LEVEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_THRESHOLD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_TOLERANCE  = 3'd6;

  // register reset values
  localparam logic [DIST_W-1:0]  RST_ERROR_SENTINEL   = 16'd65535;
  localparam logic [COUNT_W-1:0] RST_ERROR_LIMIT      = 8'd5;
  localparam logic [DIST_W-1:0]  RST_SAFE_DISTANCE    = 16'd500;
  localparam logic [DIST_W-1:0]  RST_BLIND_ZONE_LIMIT = 16'd250;
  localparam logic [DIST_W-1:0]  RST_BLIND_JUMP_LEVEL = 16'd2500;
  localparam logic [DIST_W-1:0]  RST_SPIKE_THRESHOLD  = 16'd300;
  localparam logic [COUNT_W-1:0] RST_SPIKE_TOLERANCE  = 8'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // all configuration registers
  typedef struct packed {
    logic [DIST_W-1:0]  error_sentinel;
    logic [COUNT_W-1:0] error_limit;
    logic [DIST_W-1:0]  safe_distance;
    logic [DIST_W-1:0]  blind_zone_limit;
    logic [DIST_W-1:0]  blind_jump_level;
    logic [DIST_W-1:0]  spike_threshold;
    logic [COUNT_W-1:0] spike_tolerance;
  } cfg_t;

  // filter state
  typedef struct packed {
    logic [DIST_W-1:0]  last_accepted;
    logic [COUNT_W-1:0] miss_count;
  } filt_state_t;

endpackage

### hdl/rsrf_cfg.sv
// rsrf_cfg: configuration register bank of the range spike rejection filter
// depends on rsrf_pkg
`timescale 1ns / 1ps

module rsrf_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rsrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsrf_pkg::DIST_W-1:0]    cfg_data,
  output rsrf_pkg::cfg_t                 cfg
);

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.error_sentinel   <= rsrf_pkg::RST_ERROR_SENTINEL;
      cfg.error_limit      <= rsrf_pkg::RST_ERROR_LIMIT;
      cfg.safe_distance    <= rsrf_pkg::RST_SAFE_DISTANCE;
      cfg.blind_zone_limit <= rsrf_pkg::RST_BLIND_ZONE_LIMIT;
      cfg.blind_jump_level <= rsrf_pkg::RST_BLIND_JUMP_LEVEL;
      cfg.spike_threshold  <= rsrf_pkg::RST_SPIKE_THRESHOLD;
      cfg.spike_tolerance  <= rsrf_pkg::RST_SPIKE_TOLERANCE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rsrf_pkg::CFG_ERROR_SENTINEL:   cfg.error_sentinel   <= cfg_data;
        rsrf_pkg::CFG_ERROR_LIMIT:      cfg.error_limit      <= cfg_data[rsrf_pkg::COUNT_W-1:0];
        rsrf_pkg::CFG_SAFE_DISTANCE:    cfg.safe_distance    <= cfg_data;
        rsrf_pkg::CFG_BLIND_ZONE_LIMIT: cfg.blind_zone_limit <= cfg_data;
        rsrf_pkg::CFG_BLIND_JUMP_LEVEL: cfg.blind_jump_level <= cfg_data;
        rsrf_pkg::CFG_SPIKE_THRESHOLD:  cfg.spike_threshold  <= cfg_data;
        rsrf_pkg::CFG_SPIKE_TOLERANCE:  cfg.spike_tolerance  <= cfg_data[rsrf_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/rsrf_core.sv
// rsrf_core: filter decision logic and its state registers
// depends on rsrf_pkg
`timescale 1ns / 1ps

module rsrf_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        proc,
  input  logic [rsrf_pkg::DIST_W-1:0] raw,
  input  rsrf_pkg::cfg_t              cfg,
  output logic [rsrf_pkg::DIST_W-1:0] result,
  output rsrf_pkg::filt_state_t       state
);

  rsrf_pkg::filt_state_t state_next;

  // decision for the item in the input register
  always_comb begin
    logic [rsrf_pkg::COUNT_W-1:0] miss_inc;
    logic                         is_err;
    logic                         rise;
    miss_inc = (state.miss_count == rsrf_pkg::COUNT_MAX) ? state.miss_count
             : state.miss_count + {{(rsrf_pkg::COUNT_W-1){1'b0}}, 1'b1};
    is_err   = (raw == cfg.error_sentinel);
    rise     = ({1'b0, raw} >
                ({1'b0, state.last_accepted} + {1'b0, cfg.spike_threshold}));
    state_next = state;
    result     = state.last_accepted;
    if (is_err) begin
      if (miss_inc > cfg.error_limit) begin
        state_next.last_accepted = cfg.safe_distance;
        state_next.miss_count    = '0;
        result                   = cfg.safe_distance;
      end else begin
        state_next.miss_count = miss_inc;
      end
    end else if (state.last_accepted == '0) begin
      state_next.last_accepted = raw;
      state_next.miss_count    = '0;
      result                   = raw;
    end else if ((state.last_accepted < cfg.blind_zone_limit) &&
                 (raw > cfg.blind_jump_level)) begin
      // blind zone jump is held, no state change
      result = state.last_accepted;
    end else if (rise && (miss_inc < cfg.spike_tolerance)) begin
      // unconfirmed far jump
      state_next.miss_count = miss_inc;
    end else begin
      // small change, sharp drop or confirmed far jump
      state_next.last_accepted = raw;
      state_next.miss_count    = '0;
      result                   = raw;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (proc) begin
      state <= state_next;
    end
  end

endmodule

### hdl/rsrf_outq.sv
// rsrf_outq: two-entry result queue that decouples the output side
// depends on rsrf_pkg
`timescale 1ns / 1ps

module rsrf_outq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [rsrf_pkg::DIST_W-1:0] push_data,
  output logic                        full,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [rsrf_pkg::DIST_W-1:0] m_tdata
);

  logic [rsrf_pkg::DIST_W-1:0] mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != 2'd0);
  assign full     = (count == 2'd2);
  assign m_tdata  = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### hdl/range_spike_rejection_filter.sv
// range_spike_rejection_filter: top level, input register, filter core,
// result queue and configuration bank; depends on rsrf_pkg, rsrf_cfg,
// rsrf_core and rsrf_outq
`timescale 1ns / 1ps

// Takes one raw range reading per item and returns one filtered distance per
// item. An item is accepted every cycle while the output side keeps up; it is
// held in the input register, then the filter decision is written into a
// two-entry result queue that offers the result on m_tvalid. The single
// filter state update per cycle is what sets the rate.
// Configuration writes are taken at any time but are meant to be done while
// no item is in flight.
module range_spike_rejection_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // [15:0] reading_mm
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // [15:0] filtered_distance
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  rsrf_pkg::cfg_t              cfg;
  rsrf_pkg::filt_state_t       state;
  logic                        in_valid;
  logic [rsrf_pkg::DIST_W-1:0] in_raw;
  logic                        proc;
  logic                        q_full;
  logic [rsrf_pkg::DIST_W-1:0] result;

  // input register handshake
  assign proc     = in_valid && !q_full;
  assign s_tready = !in_valid || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_raw <= s_tdata;
    end
  end

  rsrf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rsrf_core u_core (
    .clk    (clk),
    .rst    (rst),
    .proc   (proc),
    .raw    (in_raw),
    .cfg    (cfg),
    .result (result),
    .state  (state)
  );

  rsrf_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (proc),
    .push_data (result),
    .full      (q_full),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

`ifndef NO_ASSERTIONS
  // a held item never overruns a full queue
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_valid && q_full |-> !s_tready)
    else $error("input taken while result queue full");

  // a processed item shows up at the output next cycle
  a_result_visible: assert property (@(posedge clk) disable iff (rst)
    proc |=> m_tvalid)
    else $error("processed item missing from output");

  // an unprimed filter takes a good reading as is
  a_prime: assert property (@(posedge clk) disable iff (rst)
    proc && (state.last_accepted == '0) && (in_raw != cfg.error_sentinel)
    |=> (state.last_accepted == $past(in_raw)) && (state.miss_count == '0))
    else $error("priming reading not stored");

  // state does not move without a processed item
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !proc |=> $stable(state))
    else $error("filter state changed without an item");
`endif

endmodule

### verif/rsrf_distance_checker.sv
// rsrf_distance_checker: watches the reading, result and register channels of
// the range spike rejection filter, predicts each filtered distance and compares
// depends on rsrf_pkg for register indexes, reset values and cfg_t
`timescale 1ns / 1ps

module rsrf_distance_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  rsrf_pkg::cfg_t                regs;
  logic [rsrf_pkg::DIST_W-1:0]   held_dist;
  logic [rsrf_pkg::COUNT_W-1:0]  miss_cnt;
  logic [rsrf_pkg::DIST_W-1:0]   expected_dist [$];

  // shared miss counter, saturating
  function automatic void bump_misses();
    if (miss_cnt != rsrf_pkg::COUNT_MAX) miss_cnt++;
  endfunction

  // filter decision for one reading; updates the held distance and miss count
  function automatic logic [rsrf_pkg::DIST_W-1:0] predict_distance(
    input logic [rsrf_pkg::DIST_W-1:0] raw);
    int diff;
    int thr;
    if (raw == regs.error_sentinel) begin
      bump_misses();
      if (miss_cnt > regs.error_limit) begin
        held_dist = regs.safe_distance;
        miss_cnt  = '0;
      end
    end else if (held_dist == '0) begin
      // not primed: take the reading as is
      held_dist = raw;
      miss_cnt  = '0;
    end else if (held_dist < regs.blind_zone_limit && raw > regs.blind_jump_level) begin
      // blind-zone jump is held, nothing changes
    end else begin
      diff = int'(raw) - int'(held_dist);
      thr  = int'(regs.spike_threshold);
      if (diff > thr) begin
        // far jump needs confirmation
        bump_misses();
        if (miss_cnt >= regs.spike_tolerance) begin
          held_dist = raw;
          miss_cnt  = '0;
        end
      end else begin
        held_dist = raw;
        miss_cnt  = '0;
      end
    end
    return held_dist;
  endfunction

  always @(posedge clk) begin
    logic [rsrf_pkg::DIST_W-1:0] want;
    if (rst) begin
      regs.error_sentinel   = rsrf_pkg::RST_ERROR_SENTINEL;
      regs.error_limit      = rsrf_pkg::RST_ERROR_LIMIT;
      regs.safe_distance    = rsrf_pkg::RST_SAFE_DISTANCE;
      regs.blind_zone_limit = rsrf_pkg::RST_BLIND_ZONE_LIMIT;
      regs.blind_jump_level = rsrf_pkg::RST_BLIND_JUMP_LEVEL;
      regs.spike_threshold  = rsrf_pkg::RST_SPIKE_THRESHOLD;
      regs.spike_tolerance  = rsrf_pkg::RST_SPIKE_TOLERANCE;
      held_dist = '0;
      miss_cnt  = '0;
      expected_dist.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rsrf_pkg::CFG_ERROR_SENTINEL:   regs.error_sentinel   = cfg_data;
          rsrf_pkg::CFG_ERROR_LIMIT:
            regs.error_limit = cfg_data[rsrf_pkg::COUNT_W-1:0];
          rsrf_pkg::CFG_SAFE_DISTANCE:    regs.safe_distance    = cfg_data;
          rsrf_pkg::CFG_BLIND_ZONE_LIMIT: regs.blind_zone_limit = cfg_data;
          rsrf_pkg::CFG_BLIND_JUMP_LEVEL: regs.blind_jump_level = cfg_data;
          rsrf_pkg::CFG_SPIKE_THRESHOLD:  regs.spike_threshold  = cfg_data;
          rsrf_pkg::CFG_SPIKE_TOLERANCE:
            regs.spike_tolerance = cfg_data[rsrf_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      // result item against the oldest expectation
      if (m_tvalid && m_tready) begin
        if (expected_dist.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result item, distance %0d", $time, m_tdata);
          mismatches++;
        end else begin
          want = expected_dist.pop_front();
          if (m_tdata !== want) begin
            if (mismatches < 10)
              $display("%0t: filtered_distance expected %0d, got %0d",
                       $time, want, m_tdata);
            mismatches++;
          end
        end
      end
      // reading item
      if (s_tvalid && s_tready)
        expected_dist.push_back(predict_distance(s_tdata));
    end
    outstanding = expected_dist.size();
  end

endmodule

### verif/range_spike_rejection_filter_tb.sv
// range_spike_rejection_filter_tb: drives readings and register writes into
// the filter under several register settings and idle patterns; depends on
// rsrf_pkg, range_spike_rejection_filter and rsrf_distance_checker
`timescale 1ns / 1ps

module range_spike_rejection_filter_tb;

  localparam int READINGS_PER_PHASE = 135;
  localparam int PHASES             = 8;
  localparam int DRAIN_CYCLES       = 10;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  int          mismatches;
  int          outstanding;

  int             sender_idle_pct;
  int             sink_stall_pct;
  rsrf_pkg::cfg_t cur;
  int             walk_base;
  int             burst_left;
  logic [15:0]    burst_val;

  logic [15:0] directed_readings [23] = '{
    16'd0, rsrf_pkg::RST_ERROR_SENTINEL, 16'd1000, 16'd1300, 16'd1000, 16'd700,
    16'd2000, 16'd2000, 16'd2000,
    rsrf_pkg::RST_ERROR_SENTINEL, rsrf_pkg::RST_ERROR_SENTINEL,
    rsrf_pkg::RST_ERROR_SENTINEL, rsrf_pkg::RST_ERROR_SENTINEL,
    rsrf_pkg::RST_ERROR_SENTINEL, rsrf_pkg::RST_ERROR_SENTINEL,
    16'd100, 16'd3000, 16'd2400, rsrf_pkg::RST_ERROR_SENTINEL, 16'd2400,
    16'd0, 16'd65534, 16'd1
  };

  range_spike_rejection_filter dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rsrf_distance_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic logic [15:0] clamp_dist(input int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  // one reading item, with random idle cycles ahead of it
  task automatic send_reading(input logic [15:0] raw);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= raw;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // wait until every result has come back and the pipeline is empty
  task automatic drain();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // one register write; the caller drops cfg_valid after the last one
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_settings(input rsrf_pkg::cfg_t c);
    write_reg(rsrf_pkg::CFG_ERROR_SENTINEL,   c.error_sentinel);
    write_reg(rsrf_pkg::CFG_ERROR_LIMIT,      {8'd0, c.error_limit});
    write_reg(rsrf_pkg::CFG_SAFE_DISTANCE,    c.safe_distance);
    write_reg(rsrf_pkg::CFG_BLIND_ZONE_LIMIT, c.blind_zone_limit);
    write_reg(rsrf_pkg::CFG_BLIND_JUMP_LEVEL, c.blind_jump_level);
    write_reg(rsrf_pkg::CFG_SPIKE_THRESHOLD,  c.spike_threshold);
    write_reg(rsrf_pkg::CFG_SPIKE_TOLERANCE,  {8'd0, c.spike_tolerance});
    cfg_valid <= 1'b0;
    cur = c;
  endtask

  // mostly plausible range sequences: small drifts, far jumps that may or may
  // not be confirmed, drops, error bursts and blind-zone approaches; some pure noise
  task automatic next_reading(output logic [15:0] r);
    int sel;
    int thr;
    thr = int'(cur.spike_threshold);
    if (burst_left > 0) begin
      burst_left--;
      r = burst_val;
    end else begin
      sel = $urandom_range(99);
      if (sel < 10) begin
        r = cur.error_sentinel;
        burst_val  = r;
        burst_left = $urandom_range(int'(cur.error_limit) + 1) % 12;
      end else if (sel < 45) begin
        if ($urandom_range(1)) r = clamp_dist(walk_base + $urandom_range(thr));
        else r = clamp_dist(walk_base - $urandom_range(thr));
        walk_base = r;
      end else if (sel < 60) begin
        r = clamp_dist(walk_base + thr + 1 + $urandom_range(3000));
        burst_val  = r;
        burst_left = $urandom_range(int'(cur.spike_tolerance));
        walk_base  = r;
      end else if (sel < 70) begin
        r = clamp_dist(walk_base - thr - 1 - $urandom_range(2000));
        walk_base = r;
      end else if (sel < 74) begin
        r = 16'd0;
        walk_base = 0;
      end else if (sel < 84) begin
        r = (cur.blind_zone_limit == '0) ? 16'd0
          : 16'($urandom_range(int'(cur.blind_zone_limit) - 1));
        burst_val  = clamp_dist(int'(cur.blind_jump_level) + 1 + $urandom_range(5000));
        burst_left = $urandom_range(1, 2);
        walk_base  = r;
      end else begin
        r = 16'($urandom_range(65535));
        walk_base = r;
      end
    end
  endtask

  initial begin
    rsrf_pkg::cfg_t c;
    logic [15:0]    raw;
    rst             = 1'b1;
    s_tvalid        = 1'b0;
    s_tdata         = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    walk_base       = 1000;
    burst_left      = 0;
    burst_val       = '0;
    cur.error_sentinel   = rsrf_pkg::RST_ERROR_SENTINEL;
    cur.error_limit      = rsrf_pkg::RST_ERROR_LIMIT;
    cur.safe_distance    = rsrf_pkg::RST_SAFE_DISTANCE;
    cur.blind_zone_limit = rsrf_pkg::RST_BLIND_ZONE_LIMIT;
    cur.blind_jump_level = rsrf_pkg::RST_BLIND_JUMP_LEVEL;
    cur.spike_threshold  = rsrf_pkg::RST_SPIKE_THRESHOLD;
    cur.spike_tolerance  = rsrf_pkg::RST_SPIKE_TOLERANCE;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed readings on reset settings
    foreach (directed_readings[i]) send_reading(directed_readings[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        1: begin
          // low extremes: zero is the error value, fallback unprimes
          c = '{error_sentinel: 16'd0, error_limit: 8'd0, safe_distance: 16'd0,
                blind_zone_limit: 16'd0, blind_jump_level: 16'd0,
                spike_threshold: 16'd0, spike_tolerance: 8'd1};
          apply_settings(c);
        end
        2: begin
          // high extremes
          c = '{error_sentinel: 16'd12345, error_limit: 8'd254,
                safe_distance: 16'hFFFF, blind_zone_limit: 16'hFFFF,
                blind_jump_level: 16'hFFFF, spike_threshold: 16'hFFFF,
                spike_tolerance: 8'd255};
          apply_settings(c);
        end
        3: begin
          c = '{error_sentinel: 16'hFFFF, error_limit: 8'd2, safe_distance: 16'd800,
                blind_zone_limit: 16'd400, blind_jump_level: 16'd1500,
                spike_threshold: 16'd100, spike_tolerance: 8'd4};
          apply_settings(c);
        end
        default: begin
          if (ph > 3) begin
            c.error_sentinel   = 16'($urandom_range(65535));
            c.error_limit      = 8'($urandom_range(10));
            c.safe_distance    = 16'($urandom_range(4000));
            c.blind_zone_limit = 16'($urandom_range(600));
            c.blind_jump_level = 16'($urandom_range(300, 6000));
            c.spike_threshold  = 16'($urandom_range(1000));
            c.spike_tolerance  = 8'($urandom_range(1, 8));
            apply_settings(c);
          end
        end
      endcase
      case (ph % 4)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 61; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 61; end
        default: begin sender_idle_pct = 35; sink_stall_pct = 35; end
      endcase
      burst_left = 0;
      for (int n = 0; n < READINGS_PER_PHASE; n++) begin
        next_reading(raw);
        send_reading(raw);
      end
    end

    // wind down
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### files.f
hdl/rsrf_pkg.sv
hdl/rsrf_cfg.sv
hdl/rsrf_core.sv
hdl/rsrf_outq.sv
hdl/range_spike_rejection_filter.sv
verif/rsrf_distance_checker.sv
verif/range_spike_rejection_filter_tb.sv
